// ----- hdl/rsf_pkg.sv -----
// Shared types, constants and the scoring-slot decoder for the Rosenbrock/sphere fitness core.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package rsf_pkg;

    localparam int MAX_DIMENSION = 32;
    localparam int IDX_W         = $clog2(MAX_DIMENSION + 1);

    localparam int ELEM_W    = 12;
    localparam int ERR_W     = 13;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 3;
    localparam int FIT_W     = 56;
    localparam int ACC_W     = 57;
    localparam int OPD_W     = 27;
    localparam int PROD_W    = 54;
    localparam int PAIR_W    = 25;
    localparam int CNT_W     = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_EVAL_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROSEN_COUNT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPHERE_COUNT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE_MILLI  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE_ENABLE = 3'd4;

    localparam logic [1:0] MODE_PASS  = 2'd0;
    localparam logic [1:0] MODE_TYPE1 = 2'd1;
    localparam logic [1:0] MODE_TYPE2 = 2'd2;
    localparam logic [1:0] MODE_TYPE3 = 2'd3;

    localparam logic signed [OPD_W-1:0] K_ANCHOR_SCALE = 27'sd10000;
    localparam logic signed [OPD_W-1:0] K_SPHERE_SCALE = 27'sd1000000;
    localparam logic signed [ERR_W-1:0] OPTIMUM        = 13'sd1000;
    localparam logic [ACC_W-1:0]        FIT_MAX        = 57'd70000000000000000;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_ANCHOR,
        KIND_ROSEN,
        KIND_SPHERE,
        KIND_PAIR_FIRST,
        KIND_PAIR_SECOND
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ANCH_K,
        ST_SQ_B,
        ST_SUB,
        ST_SQ_D,
        ST_SQ_E,
        ST_SCALE,
        ST_PAIR_SUM,
        ST_SQ_S,
        ST_ACC,
        ST_FIN
    } state_t;

    typedef struct packed {
        state_t state;
        kind_t  kind;
        logic   take;
        logic   vec_done;
    } dp_cmd_t;

    // Decides what an element at position idx contributes under the current registers.
    function automatic kind_t decode_kind(
        input logic [1:0]       mode,
        input logic [4:0]       t,
        input logic [5:0]       l,
        input logic [IDX_W-1:0] idx
    );
        logic [7:0] i8;
        logic [7:0] t8;
        logic [7:0] l8;
        kind_t      k;
        i8 = 8'(idx);
        t8 = 8'(t);
        l8 = 8'(l);
        k  = KIND_NONE;
        if (i8 < 8'(MAX_DIMENSION))
        begin
            unique case (mode) inside
                MODE_TYPE1:
                begin
                    if (i8 < t8)
                    begin
                        k = (i8 == 8'd0) ? KIND_ANCHOR : KIND_ROSEN;
                    end
                    else if (i8 < t8 + l8)
                    begin
                        k = KIND_SPHERE;
                    end
                end
                MODE_TYPE2, MODE_TYPE3:
                begin
                    if (i8 < (t8 << 1))
                    begin
                        k = i8[0] ? KIND_ROSEN : KIND_ANCHOR;
                    end
                    else if (mode == MODE_TYPE2)
                    begin
                        if (i8 < (t8 << 1) + l8)
                        begin
                            k = KIND_SPHERE;
                        end
                    end
                    else if (i8 < (t8 << 2))
                    begin
                        k = i8[0] ? KIND_PAIR_SECOND : KIND_PAIR_FIRST;
                    end
                end
                default:
                begin
                    k = KIND_NONE;
                end
            endcase
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/rsf_seq.sv -----
// Sequencer of the fitness core: element index, per-element micro-step state machine.
// Depends on rsf_pkg; drives the datapath through a dp_cmd_t command.
`default_nettype none

module rsf_seq
    import rsf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       last_element,
    input  wire logic [1:0] eval_mode,
    input  wire logic [4:0] rosen_count,
    input  wire logic [5:0] sphere_count,
    input  wire logic       out_busy,
    output logic            in_ready,
    output dp_cmd_t         cmd
);

    state_t           state_reg;
    state_t           state_next;
    kind_t            kind_reg;
    kind_t            kind_in;
    logic             last_reg;
    logic [IDX_W-1:0] index_reg;
    logic             take;
    logic             vec_done;

    assign kind_in  = decode_kind(eval_mode, rosen_count, sphere_count, index_reg);
    assign take     = (state_reg == ST_IDLE) && in_valid;
    assign vec_done = (state_reg == ST_FIN) && last_reg && !out_busy;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (kind_in) inside
                        KIND_ROSEN:
                        begin
                            state_next = ST_ANCH_K;
                        end
                        KIND_SPHERE, KIND_PAIR_FIRST, KIND_PAIR_SECOND:
                        begin
                            state_next = ST_SQ_E;
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_ANCH_K:   state_next = ST_SQ_B;
            ST_SQ_B:     state_next = ST_SUB;
            ST_SUB:      state_next = ST_SQ_D;
            ST_SQ_D:     state_next = ST_SQ_E;
            ST_SQ_E:
            begin
                if (kind_reg == KIND_PAIR_FIRST || kind_reg == KIND_PAIR_SECOND)
                begin
                    state_next = ST_PAIR_SUM;
                end
                else
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:    state_next = ST_ACC;
            ST_PAIR_SUM:
            begin
                state_next = (kind_reg == KIND_PAIR_SECOND) ? ST_SQ_S : ST_FIN;
            end
            ST_SQ_S:     state_next = ST_ACC;
            ST_ACC:      state_next = ST_FIN;
            ST_FIN:
            begin
                if (!(last_reg && out_busy))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = (state_reg == ST_IDLE);
        cmd.state    = state_reg;
        cmd.kind     = (state_reg == ST_IDLE) ? kind_in : kind_reg;
        cmd.take     = take;
        cmd.vec_done = vec_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= KIND_NONE;
            last_reg  <= 1'b0;
            index_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (take)
            begin
                kind_reg <= kind_in;
                last_reg <= last_element;
                if (index_reg < IDX_W'(MAX_DIMENSION))
                begin
                    index_reg <= index_reg + IDX_W'(1);
                end
            end
            else if (vec_done)
            begin
                index_reg <= '0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/rsf_dp.sv -----
// Datapath of the fitness core: one shared 27x27 signed multiplier, a working register,
// the product register and the saturating fitness accumulator. Depends on rsf_pkg.
`default_nettype none

module rsf_dp
    import rsf_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire dp_cmd_t                  cmd,
    input  wire logic signed [ELEM_W-1:0] element_value,
    output logic [ACC_W-1:0]              acc
);

    logic signed [ELEM_W-1:0] elem_reg;
    logic signed [ELEM_W-1:0] anchor_reg;
    logic signed [OPD_W-1:0]  w_reg;
    logic signed [OPD_W-1:0]  w_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic [PAIR_W-1:0]        pair_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         acc_next;
    logic [ACC_W-1:0]         acc_sum;
    logic signed [ERR_W-1:0]  err;
    logic signed [15:0]       elem_ext;
    logic signed [15:0]       elem10;
    logic signed [OPD_W-1:0]  prod_low;
    logic signed [OPD_W-1:0]  mul_a;
    logic signed [OPD_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] product;
    logic                     prod_load;
    logic                     acc_add;

    assign err      = $signed({elem_reg[ELEM_W-1], elem_reg}) - OPTIMUM;
    assign elem_ext = {{(16 - ELEM_W){elem_reg[ELEM_W-1]}}, elem_reg};
    assign elem10   = (elem_ext <<< 3) + (elem_ext <<< 1);
    assign prod_low = $signed(prod_reg[OPD_W-1:0]);
    assign product  = mul_a * mul_b;
    assign acc      = acc_reg;

    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        prod_load = 1'b1;
        case (cmd.state)
            ST_ANCH_K:
            begin
                mul_a = {{(OPD_W - ELEM_W){anchor_reg[ELEM_W-1]}}, anchor_reg};
                mul_b = K_ANCHOR_SCALE;
            end
            ST_SQ_B:
            begin
                mul_a = {{(OPD_W - ELEM_W){elem_reg[ELEM_W-1]}}, elem_reg};
                mul_b = {{(OPD_W - 16){elem10[15]}}, elem10};
            end
            ST_SQ_D, ST_SQ_S:
            begin
                mul_a = w_reg;
                mul_b = w_reg;
            end
            ST_SQ_E:
            begin
                mul_a = {{(OPD_W - ERR_W){err[ERR_W-1]}}, err};
                mul_b = {{(OPD_W - ERR_W){err[ERR_W-1]}}, err};
            end
            ST_SCALE:
            begin
                mul_a = prod_low;
                mul_b = K_SPHERE_SCALE;
            end
            default:
            begin
                prod_load = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        w_next = w_reg;
        case (cmd.state)
            ST_SQ_B:     w_next = prod_low;
            ST_SUB:      w_next = w_reg - prod_low;
            ST_PAIR_SUM: w_next = $signed(OPD_W'(pair_reg)) + prod_low;
            default:     w_next = w_reg;
        endcase
    end

    // All terms are nonnegative and below 2^53, so the sum cannot wrap 57 bits.
    assign acc_add = (cmd.state == ST_ACC) ||
                     ((cmd.state == ST_SQ_E) && (cmd.kind == KIND_ROSEN));
    assign acc_sum = acc_reg + {{(ACC_W - (PROD_W - 1)){1'b0}}, prod_reg[PROD_W-2:0]};

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.vec_done)
        begin
            acc_next = '0;
        end
        else if (acc_add)
        begin
            acc_next = (acc_sum > FIT_MAX) ? FIT_MAX : acc_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            elem_reg <= element_value;
        end
        if (prod_load)
        begin
            prod_reg <= product;
        end
        w_reg <= w_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor_reg <= '0;
            pair_reg   <= '0;
            acc_reg    <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (cmd.vec_done)
            begin
                anchor_reg <= '0;
                pair_reg   <= '0;
            end
            else
            begin
                if (cmd.take && cmd.kind == KIND_ANCHOR)
                begin
                    anchor_reg <= element_value;
                end
                if (cmd.state == ST_PAIR_SUM && cmd.kind == KIND_PAIR_FIRST)
                begin
                    pair_reg <= prod_reg[PAIR_W-1:0];
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/rosenbrock_sphere_fitness_core.sv -----
// Top level of the Rosenbrock/sphere fitness core: configuration registers, tolerance check,
// result register. Depends on rsf_pkg, rsf_seq and rsf_dp.
//
// Elements of a candidate vector enter one beat at a time in milli units, and the beat marked
// last_element yields one result beat with the saturated fitness, the in-tolerance flag, the
// sticky end flag and the evaluation count. All multiplications run on one shared 27x27 signed
// multiplier stepped by a small sequencer, and the input is not ready while an element is
// in work. An element goes through the most sequencer states when it adds a Rosenbrock term,
// fewer for a sphere term or a squared pair, and the fewest when it only sets the anchor or
// adds nothing. A last element may also wait in the sequencer while the previous result is
// still held in the output register.
`default_nettype none

module rosenbrock_sphere_fitness_core
    import rsf_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_W-1:0]         cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic signed [ELEM_W-1:0] element_value,
    input  wire logic                     last_element,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [FIT_W-1:0]              fitness,
    output logic                          vector_in_tolerance,
    output logic                          end_flag,
    output logic [CNT_W-1:0]              evaluation_count
);

    logic [1:0]              eval_mode_reg;
    logic [4:0]              rosen_count_reg;
    logic [5:0]              sphere_count_reg;
    logic [ELEM_W-1:0]       tolerance_milli_reg;
    logic                    tolerance_enable_reg;
    logic                    all_within_reg;
    logic                    sticky_reg;
    logic                    sticky_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    out_valid_reg;
    logic [FIT_W-1:0]        fitness_reg;
    logic                    in_tol_reg;
    logic                    out_busy;
    logic signed [ERR_W-1:0] dev;
    logic [ERR_W-1:0]        mag;
    logic                    elem_ok;
    logic [ACC_W-1:0]        acc;
    dp_cmd_t                 cmd;

    assign out_busy = out_valid_reg && !out_ready;

    rsf_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .last_element (last_element),
        .eval_mode    (eval_mode_reg),
        .rosen_count  (rosen_count_reg),
        .sphere_count (sphere_count_reg),
        .out_busy     (out_busy),
        .in_ready     (in_ready),
        .cmd          (cmd)
    );

    rsf_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .element_value (element_value),
        .acc           (acc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval_mode_reg        <= MODE_TYPE1;
            rosen_count_reg      <= 5'd2;
            sphere_count_reg     <= 6'd20;
            tolerance_milli_reg  <= 12'd1;
            tolerance_enable_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EVAL_MODE:        eval_mode_reg        <= cfg_data[1:0];
                CFG_ROSEN_COUNT:      rosen_count_reg      <= cfg_data[4:0];
                CFG_SPHERE_COUNT:     sphere_count_reg     <= cfg_data[5:0];
                CFG_TOLERANCE_MILLI:  tolerance_milli_reg  <= cfg_data[ELEM_W-1:0];
                CFG_TOLERANCE_ENABLE: tolerance_enable_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // An element is within tolerance when twice its distance from the optimum fits the band.
    assign dev     = $signed({element_value[ELEM_W-1], element_value}) - OPTIMUM;
    assign mag     = dev[ERR_W-1] ? ERR_W'(-dev) : ERR_W'(dev);
    assign elem_ok = {mag, 1'b0} <= {2'b00, tolerance_milli_reg};

    assign sticky_next = sticky_reg || (tolerance_enable_reg && all_within_reg);
    assign count_next  = count_reg + CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            all_within_reg <= 1'b1;
            sticky_reg     <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                all_within_reg <= all_within_reg && elem_ok;
            end
            else if (cmd.vec_done)
            begin
                all_within_reg <= 1'b1;
            end
            if (cmd.vec_done)
            begin
                sticky_reg    <= sticky_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.vec_done)
        begin
            fitness_reg <= (eval_mode_reg == MODE_PASS) ? '0 : acc[FIT_W-1:0];
            in_tol_reg  <= all_within_reg;
        end
    end

    assign out_valid           = out_valid_reg;
    assign fitness             = fitness_reg;
    assign vector_in_tolerance = in_tol_reg;
    assign end_flag            = sticky_reg;
    assign evaluation_count    = count_reg;

endmodule

`default_nettype wire

// ----- hdl/rsf_checker.sv -----
// Port-level checker for the fitness core, bound to its top level.
// Depends on rsf_pkg and on the port names of rosenbrock_sphere_fitness_core.
`default_nettype none

module rsf_checker
    import rsf_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_ready,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire logic [FIT_W-1:0] fitness,
    input wire logic             end_flag,
    input wire logic [CNT_W-1:0] evaluation_count
);

    // Every accepted element leaves the sequencer busy and drops in_ready.
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after an accepted beat");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(fitness) &&
        $stable(evaluation_count))
        else $error("stalled result beat changed");

    a_fit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> fitness <= FIT_MAX[FIT_W-1:0])
        else $error("fitness above the saturation bound");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid ||
        evaluation_count == $past(evaluation_count) + 32'd1)
        else $error("evaluation count did not advance by one");

    a_end_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && end_flag |=> !out_valid || end_flag)
        else $error("end flag dropped");

endmodule

bind rosenbrock_sphere_fitness_core rsf_checker u_rsf_checker (.*);

`default_nettype wire

// ----- test/tb_rosenbrock_sphere_fitness_core.sv -----
// Testbench for rosenbrock_sphere_fitness_core: streams candidate vectors through the element
// channel, predicts each score beat in a small tracker class and compares every field.
// Depends on rsf_pkg and the core RTL only.

module tb_rosenbrock_sphere_fitness_core
    import rsf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 600;
    localparam int DIRECTED_MAX  = 30;
    localparam int QUIET_AFTER   = 600;
    localparam int VECTOR_SLOTS  = 32;
    localparam longint unsigned FIT_CEILING = 64'd70000000000000000;

    typedef struct packed {
        logic [FIT_W-1:0] fitness;
        logic             in_tol;
        logic             end_seen;
        logic [CNT_W-1:0] count;
    } score_t;

    class fitness_tracker;
        logic [1:0]       mode;
        logic [4:0]       rosen_n;
        logic [5:0]       sphere_n;
        logic [CFG_W-1:0] tol_milli;
        logic             tol_on;
        int               position;
        longint           anchor;
        longint unsigned  pair_err;
        longint unsigned  acc;
        bit               all_ok;
        bit               sticky;
        logic [CNT_W-1:0] vectors;
        score_t           pending_scores[$];
        int               scores_checked;
        int               errors;
        int               in_tol_seen;
        int               saturated_seen;

        function new();
            mode = MODE_TYPE1;
            rosen_n = 5'd2;
            sphere_n = 6'd20;
            tol_milli = 12'd1;
            tol_on = 1'b1;
            sticky = 1'b0;
            vectors = '0;
            scores_checked = 0;
            errors = 0;
            in_tol_seen = 0;
            saturated_seen = 0;
            clear_vector();
        endfunction

        function void clear_vector();
            position = 0;
            anchor = 0;
            pair_err = 0;
            acc = 0;
            all_ok = 1'b1;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_EVAL_MODE:        mode = data[1:0];
                CFG_ROSEN_COUNT:      rosen_n = data[4:0];
                CFG_SPHERE_COUNT:     sphere_n = data[5:0];
                CFG_TOLERANCE_MILLI:  tol_milli = data;
                CFG_TOLERANCE_ENABLE: tol_on = data[0];
                default:              ;
            endcase
        endfunction

        function longint unsigned err_sq(longint b);
            return longint'((b - 1000) * (b - 1000));
        endfunction

        function longint unsigned rosen_term(longint a, longint b);
            longint d;
            d = a * 1000 - b * b;
            return longint'(100 * d * d) + err_sq(b) * 1000000;
        endfunction

        function void add_term(longint unsigned term);
            longint unsigned sum;
            sum = acc + term;
            acc = (sum > FIT_CEILING) ? FIT_CEILING : sum;
        endfunction

        function void accumulate(int i, longint b);
            int t;
            int l;
            t = rosen_n;
            l = sphere_n;
            if (mode == MODE_TYPE1)
            begin
                if (i < t)
                begin
                    if (i == 0)
                        anchor = b;
                    else
                        add_term(rosen_term(anchor, b));
                end
                else if (i < t + l)
                    add_term(err_sq(b) * 1000000);
            end
            else if (mode == MODE_TYPE2 || mode == MODE_TYPE3)
            begin
                if (i < 2 * t)
                begin
                    if (i % 2 == 0)
                        anchor = b;
                    else
                        add_term(rosen_term(anchor, b));
                end
                else if (mode == MODE_TYPE2)
                begin
                    if (i < 2 * t + l)
                        add_term(err_sq(b) * 1000000);
                end
                else if (i < 4 * t)
                begin
                    if (i % 2 == 0)
                        pair_err = err_sq(b);
                    else
                        add_term((pair_err + err_sq(b)) * (pair_err + err_sq(b)));
                end
            end
        endfunction

        function void take_element(logic signed [ELEM_W-1:0] value, logic last);
            longint b;
            longint mag;
            score_t s;
            b = value;
            mag = (b >= 1000) ? b - 1000 : 1000 - b;
            if (2 * mag > longint'(tol_milli))
                all_ok = 1'b0;
            if (position < VECTOR_SLOTS)
            begin
                accumulate(position, b);
                position++;
            end
            if (!last)
                return;
            if (tol_on && all_ok)
                sticky = 1'b1;
            vectors = vectors + 1'b1;
            s.fitness = (mode == MODE_PASS) ? '0 : FIT_W'(acc);
            s.in_tol = all_ok;
            s.end_seen = sticky;
            s.count = vectors;
            if (all_ok)
                in_tol_seen++;
            if (mode != MODE_PASS && acc == FIT_CEILING)
                saturated_seen++;
            pending_scores = {pending_scores, s};
            clear_vector();
        endfunction

        function void compare_score(logic [FIT_W-1:0] fit, logic in_tol, logic end_seen,
                                    logic [CNT_W-1:0] count);
            score_t e;
            if (pending_scores.size() == 0)
            begin
                $error("unexpected score beat: fitness %0d, count %0d", fit, count);
                errors++;
                return;
            end
            e = pending_scores.pop_front();
            scores_checked++;
            if (fit !== e.fitness)
            begin
                $error("fitness: expected %0d, got %0d", e.fitness, fit);
                errors++;
            end
            if (in_tol !== e.in_tol)
            begin
                $error("vector_in_tolerance: expected %0d, got %0d", e.in_tol, in_tol);
                errors++;
            end
            if (end_seen !== e.end_seen)
            begin
                $error("end_flag: expected %0d, got %0d", e.end_seen, end_seen);
                errors++;
            end
            if (count !== e.count)
            begin
                $error("evaluation_count: expected %0d, got %0d", e.count, count);
                errors++;
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_W-1:0]         cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic signed [ELEM_W-1:0] element_value = '0;
    logic                     last_element = 1'b0;
    logic                     out_valid;
    logic                     out_ready = 1'b1;
    logic [FIT_W-1:0]         fitness;
    logic                     vector_in_tolerance;
    logic                     end_flag;
    logic [CNT_W-1:0]         evaluation_count;

    fitness_tracker tracker;
    int             elements_sent = 0;
    int             settings_used = 0;
    bit             quiet = 1'b0;
    bit             hold_request = 1'b0;

    rosenbrock_sphere_fitness_core dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .element_value       (element_value),
        .last_element        (last_element),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .fitness             (fitness),
        .vector_in_tolerance (vector_in_tolerance),
        .end_flag            (end_flag),
        .evaluation_count    (evaluation_count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.compare_score(fitness, vector_in_tolerance, end_flag, evaluation_count);
    end

    task automatic idle_input(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic send_element(int value, bit last);
        in_valid <= 1'b1;
        element_value <= ELEM_W'(value);
        last_element <= last;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.take_element(ELEM_W'(value), last);
        elements_sent++;
        if (elements_sent >= QUIET_AFTER)
            quiet = 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0)
            idle_input($urandom_range(1, 14));
    endtask

    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (tracker.pending_scores.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(value);
        @(posedge clk);
        tracker.write_register(idx, CFG_W'(value));
    endtask

    task automatic write_regs(int mode, int rosen, int sphere, int tol, int tol_en);
        write_reg(CFG_EVAL_MODE, mode);
        write_reg(CFG_ROSEN_COUNT, rosen);
        write_reg(CFG_SPHERE_COUNT, sphere);
        write_reg(CFG_TOLERANCE_MILLI, tol);
        write_reg(CFG_TOLERANCE_ENABLE, tol_en);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic int pick_value(int style, int tol);
        int v;
        case (style)
            0:
            begin
                v = 1000 + int'($urandom_range(0, tol / 2));
                if ($urandom_range(0, 1) == 1)
                    v = 2000 - v;
            end
            1:       v = int'($urandom_range(0, 4095)) - 2048;
            2:
            begin
                case ($urandom_range(0, 6))
                    0:       v = -2048;
                    1:       v = 2047;
                    2:       v = 1000;
                    3:       v = 0;
                    4:       v = -1;
                    5:       v = 999;
                    default: v = 1001;
                endcase
            end
            default: v = 950 + int'($urandom_range(0, 100));
        endcase
        if (v > 2047)
            v = 2047;
        if (v < -2048)
            v = -2048;
        return v;
    endfunction

    task automatic run_phase(int phase_no);
        int mode;
        int rosen;
        int sphere;
        int tol;
        int tol_en;
        int vec_count;
        int len;
        int style;
        int v;
        int k;
        wait_until_drained();
        mode = $urandom_range(0, 3);
        case ($urandom_range(0, 5))
            0:       rosen = 1;
            1:       rosen = 16;
            2:       rosen = 0;
            3:       rosen = 31;
            default: rosen = $urandom_range(1, 16);
        endcase
        case ($urandom_range(0, 4))
            0:       sphere = 0;
            1:       sphere = 32;
            2:       sphere = 63;
            default: sphere = $urandom_range(0, 32);
        endcase
        case ($urandom_range(0, 3))
            0:       tol = 0;
            1:       tol = 4095;
            default: tol = $urandom_range(0, 600);
        endcase
        tol_en = ($urandom_range(0, 3) == 0) ? 0 : 1;
        if (phase_no == 1)
        begin
            mode = MODE_TYPE1;
            rosen = 31;
            tol = 4095;
        end
        write_regs(mode, rosen, sphere, tol, tol_en);
        if (phase_no == 3)
            hold_request = 1'b1;
        if (phase_no == 1)
        begin
            send_element(-2048, 1'b0);
            for (k = 0; k < 35; k++)
                send_element((k % 2 == 1) ? -2048 : 2047, k == 34);
        end
        vec_count = $urandom_range(3, 8);
        for (v = 0; v < vec_count; v++)
        begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
            style = $urandom_range(0, 3);
            for (k = 0; k < len; k++)
                send_element(pick_value(style, tol), k == len - 1);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            len = $urandom_range(1, 4);
            for (k = 0; k < len; k++)
                send_element(pick_value(1, tol), 1'b0);
        end
    endtask

    initial
    begin : result_sink
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int stalled_cycles;
        stalled_cycles = 0;
        while (stalled_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                stalled_cycles = 0;
            else
                stalled_cycles++;
        end
        $display("[rosenbrock_sphere_fitness_core] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int phase_no;
        tracker = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_element(1000, 1'b0);
        send_element(1000, 1'b0);
        send_element(1000, 1'b1);
        send_element(-2048, 1'b0);
        send_element(2047, 1'b1);

        wait_until_drained();
        write_regs(MODE_TYPE2, 1, 2, 4095, 0);
        send_element(2047, 1'b0);
        send_element(-2048, 1'b0);
        send_element(0, 1'b0);
        send_element(1500, 1'b0);
        send_element(7, 1'b1);

        wait_until_drained();
        write_regs(MODE_TYPE3, 2, 0, 0, 1);
        repeat (6) send_element(1000, 1'b0);
        send_element(1000, 1'b1);

        wait_until_drained();
        write_regs(MODE_TYPE1, 0, 63, 2000, 1);
        send_element(1000, 1'b0);
        send_element(0, 1'b0);
        send_element(2047, 1'b1);
        send_element(123, 1'b0);
        wait_until_drained();
        write_regs(MODE_PASS, 3, 5, 2000, 1);
        send_element(-5, 1'b1);
        send_element(500, 1'b0);
        wait_until_drained();
        write_regs(MODE_TYPE1, 0, 63, 2000, 1);
        send_element(-700, 1'b1);

        phase_no = 0;
        while (elements_sent < DIRECTED_MAX + RANDOM_ITEMS)
        begin
            run_phase(phase_no);
            phase_no++;
        end

        wait_until_drained();
        $display("Scored %0d vectors from %0d elements under %0d register settings.",
                 tracker.scores_checked, elements_sent, settings_used);
        $display("%0d vectors were within tolerance and %0d reached the fitness ceiling.",
                 tracker.in_tol_seen, tracker.saturated_seen);
        if (tracker.errors == 0 && tracker.pending_scores.size() == 0)
            $display("[rosenbrock_sphere_fitness_core] OK");
        else
            $display("[rosenbrock_sphere_fitness_core] ERROR");
        $finish;
    end

endmodule
